[rtl/osh_pkg.sv]
// ----------------------------------------------------------------------------
// osh_pkg
// Shared types, codes and the sine evaluation used for the heading tables.
// ----------------------------------------------------------------------------
package osh_pkg;

    // request kinds
    localparam logic [1:0] KIND_POSE = 2'd0;
    localparam logic [1:0] KIND_SCAN = 2'd1;
    localparam logic [1:0] KIND_CMD  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_X    = 3'd0;
    localparam logic [2:0] CFG_TARGET_Y    = 3'd1;
    localparam logic [2:0] CFG_SAFETY_SQ   = 3'd2;
    localparam logic [2:0] CFG_CRUISE      = 3'd3;
    localparam logic [2:0] CFG_STEER_LIMIT = 3'd4;
    localparam logic [2:0] CFG_CENTER_BAND = 3'd5;

    localparam int CFG_DATA_W = 35;
    localparam int DIST_W     = 35;

    localparam logic [DIST_W-1:0] SAFETY_SQ_RST   = 35'd262144;
    localparam logic [15:0]       CRUISE_RST      = 16'd512;
    localparam logic [14:0]       STEER_LIMIT_RST = 15'd6554;
    localparam logic [31:0]       CENTER_BAND_RST = 32'd4194;

    // polynomial coefficients, Q28
    localparam longint C1 = 421657428;
    localparam longint C3 = 173399667;
    localparam longint C5 = 21392326;
    localparam longint C7 = 1256750;
    localparam longint C9 = 43069;

    typedef enum logic [1:0] {
        DIR_STRAIGHT = 2'd0,
        DIR_LEFT     = 2'd1,
        DIR_RIGHT    = 2'd2,
        DIR_STOP     = 2'd3
    } osh_dir_t;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [DIST_W-1:0]  safety_sq;
        logic [15:0]        cruise;
        logic [14:0]        steer_limit;
        logic [31:0]        center_band;
    } osh_cfg_t;

    typedef struct packed {
        logic [15:0]        speed;
        logic signed [15:0] steering;
        osh_dir_t           dir;
    } osh_result_t;

    // quarter wave, r in 0..16384, result Q14
    function automatic longint quarter_sine(input longint r);
        longint x2;
        longint t;
        x2 = (r * r) >>> 14;
        t  = C9;
        t  = C7 - ((x2 * t) >>> 14);
        t  = C5 - ((x2 * t) >>> 14);
        t  = C3 - ((x2 * t) >>> 14);
        t  = C1 - ((x2 * t) >>> 14);
        t  = (r * t + (longint'(1) << 27)) >>> 28;
        if (t > 16384)
            t = 16384;
        return t;
    endfunction

    // sine of a 16-bit phase, signed Q1.14
    function automatic logic signed [15:0] phase_sine(input logic [15:0] p);
        longint r;
        longint s;
        r = longint'(p[13:0]);
        if (p[14])
            s = quarter_sine(16384 - r);
        else
            s = quarter_sine(r);
        if (p[15])
            s = -s;
        return 16'(s);
    endfunction

endpackage

[rtl/osh_trig_rom.sv]
// ----------------------------------------------------------------------------
// osh_trig_rom
// Sine and cosine tables indexed by the quantized heading, registered read.
// ----------------------------------------------------------------------------
module osh_trig_rom #(
    parameter int ENTRIES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [15:0]        heading,
    output logic signed [15:0] sin_val,
    output logic signed [15:0] cos_val
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PW    = 16 + IDX_W + 1;

    logic signed [15:0] sin_tab [ENTRIES];
    logic signed [15:0] cos_tab [ENTRIES];
    logic [PW-1:0]      prod;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_tab
        localparam logic [15:0] PH = 16'((longint'(i) * 65536) / ENTRIES);
        assign sin_tab[i] = osh_pkg::phase_sine(PH);
        assign cos_tab[i] = osh_pkg::phase_sine(PH + 16'd16384);
    end

    // entry = (heading * entries) >> 16
    assign prod = PW'(heading) * PW'(ENTRIES);
    assign idx  = prod[16 +: IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg <= osh_pkg::phase_sine(16'd0);
            cos_reg <= osh_pkg::phase_sine(16'd16384);
        end
        else if (load)
        begin
            sin_reg <= sin_tab[idx];
            cos_reg <= cos_tab[idx];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

[rtl/osh_scan_min.sv]
// ----------------------------------------------------------------------------
// osh_scan_min
// Running minimum of squared scan point distance, closest obstacle per scan.
// ----------------------------------------------------------------------------
module osh_scan_min (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       is_last,
    input  logic signed [15:0]         pose_x,
    input  logic signed [15:0]         pose_y,
    input  logic signed [15:0]         pt_x,
    input  logic signed [15:0]         pt_y,
    output logic [osh_pkg::DIST_W-1:0] closest_sq
);

    localparam int DW = osh_pkg::DIST_W;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] sqx;
    logic signed [33:0] sqy;
    logic [DW-1:0]      pt_dist_sq;
    logic [DW-1:0]      min_new;
    logic [DW-1:0]      scan_min_reg;
    logic [DW-1:0]      scan_min_next;
    logic [DW-1:0]      closest_reg;
    logic [DW-1:0]      closest_next;

    assign dx   = {pose_x[15], pose_x} - {pt_x[15], pt_x};
    assign dy   = {pose_y[15], pose_y} - {pt_y[15], pt_y};
    assign sqx  = dx * dx;
    assign sqy  = dy * dy;
    assign pt_dist_sq = DW'($unsigned(sqx)) + DW'($unsigned(sqy));

    assign min_new = (pt_dist_sq < scan_min_reg) ? pt_dist_sq : scan_min_reg;

    always_comb
    begin
        scan_min_next = scan_min_reg;
        closest_next  = closest_reg;
        if (en)
        begin
            if (is_last)
            begin
                closest_next  = min_new;
                scan_min_next = '1;
            end
            else
            begin
                scan_min_next = min_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_min_reg <= '1;
            closest_reg  <= '0;
        end
        else
        begin
            scan_min_reg <= scan_min_next;
            closest_reg  <= closest_next;
        end
    end

    assign closest_sq = closest_reg;

    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (en && is_last) |=> (scan_min_reg == {DW{1'b1}}))
        else $error("scan minimum not restarted after last point");

endmodule

[rtl/osh_steer_calc.sv]
// ----------------------------------------------------------------------------
// osh_steer_calc
// Stop check and left/right/straight choice from the heading dot product.
// ----------------------------------------------------------------------------
module osh_steer_calc (
    input  osh_pkg::osh_cfg_t          cfg,
    input  logic signed [15:0]         pose_x,
    input  logic signed [15:0]         pose_y,
    input  logic signed [15:0]         sin_val,
    input  logic signed [15:0]         cos_val,
    input  logic [osh_pkg::DIST_W-1:0] closest_sq,
    output osh_pkg::osh_result_t       result
);

    logic signed [16:0] tdx;
    logic signed [16:0] tdy;
    logic signed [33:0] p_sin;
    logic signed [33:0] p_cos;
    logic signed [33:0] dot;
    logic [33:0]        mag;
    logic               clear;

    assign tdx   = {cfg.target_x[15], cfg.target_x} - {pose_x[15], pose_x};
    assign tdy   = {cfg.target_y[15], cfg.target_y} - {pose_y[15], pose_y};
    assign p_sin = sin_val * tdx;
    assign p_cos = cos_val * tdy;
    // right vector is (-sin, cos)
    assign dot   = p_cos - p_sin;
    assign mag   = dot[33] ? $unsigned(-dot) : $unsigned(dot);
    assign clear = closest_sq > cfg.safety_sq;

    always_comb
    begin
        result.speed    = '0;
        result.steering = '0;
        result.dir      = osh_pkg::DIR_STOP;
        if (clear)
        begin
            result.speed = cfg.cruise;
            if (mag < {2'b00, cfg.center_band})
            begin
                result.dir = osh_pkg::DIR_STRAIGHT;
            end
            else if (dot[33])
            begin
                result.dir      = osh_pkg::DIR_LEFT;
                result.steering = -$signed({1'b0, cfg.steer_limit});
            end
            else
            begin
                result.dir      = osh_pkg::DIR_RIGHT;
                result.steering = $signed({1'b0, cfg.steer_limit});
            end
        end
    end

endmodule

[rtl/obstacle_stop_heading_steer_core.sv]
// ----------------------------------------------------------------------------
// obstacle_stop_heading_steer_core
// Reactive drive controller: obstacle stop with heading based steering.
// ----------------------------------------------------------------------------
// command path: input register, then result register; out_stall holds the result
// throughput: one request per cycle of any kind while out_stall is low;
//   set by the single input stage and the result register, with the trig table
//   read on a pose update
// reset: asynchronous, active low; pose and heading zero, scan minimum all ones,
//   closest obstacle zero (stopped until a scan completes), registers at defaults
module obstacle_stop_heading_steer_core #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic signed [15:0]                 x_coord,
    input  logic signed [15:0]                 y_coord,
    input  logic [15:0]                        heading,
    input  logic                               is_last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        forward_speed,
    output logic signed [15:0]                 steering,
    output logic [1:0]                         turn_direction,
    input  logic                               cfg_write,
    input  logic [2:0]                         cfg_index,
    input  logic [osh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    osh_pkg::osh_cfg_t    cfg_reg;
    osh_pkg::osh_result_t calc;
    osh_pkg::osh_result_t res_reg;

    logic                 in_accept;
    logic                 s1_valid_reg;
    logic [1:0]           s1_kind_reg;
    logic signed [15:0]   s1_x_reg;
    logic signed [15:0]   s1_y_reg;
    logic                 s1_last_reg;
    logic                 s1_is_cmd;
    logic                 s1_adv;
    logic                 out_free;
    logic                 out_valid_reg;

    logic signed [15:0]   pose_x_reg;
    logic signed [15:0]   pose_y_reg;
    logic                 pose_load;
    logic signed [15:0]   sin_val;
    logic signed [15:0]   cos_val;
    logic [osh_pkg::DIST_W-1:0] closest_sq;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_x    <= '0;
            cfg_reg.target_y    <= '0;
            cfg_reg.safety_sq   <= osh_pkg::SAFETY_SQ_RST;
            cfg_reg.cruise      <= osh_pkg::CRUISE_RST;
            cfg_reg.steer_limit <= osh_pkg::STEER_LIMIT_RST;
            cfg_reg.center_band <= osh_pkg::CENTER_BAND_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                osh_pkg::CFG_TARGET_X:    cfg_reg.target_x    <= $signed(cfg_data[15:0]);
                osh_pkg::CFG_TARGET_Y:    cfg_reg.target_y    <= $signed(cfg_data[15:0]);
                osh_pkg::CFG_SAFETY_SQ:   cfg_reg.safety_sq   <= cfg_data;
                osh_pkg::CFG_CRUISE:      cfg_reg.cruise      <= cfg_data[15:0];
                osh_pkg::CFG_STEER_LIMIT: cfg_reg.steer_limit <= cfg_data[14:0];
                osh_pkg::CFG_CENTER_BAND: cfg_reg.center_band <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // handshake; only a command can be held back by the result register
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_is_cmd = (s1_kind_reg == osh_pkg::KIND_CMD);
    assign s1_adv    = s1_valid_reg && (!s1_is_cmd || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign pose_load = in_accept && (kind == osh_pkg::KIND_POSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_x_reg    <= x_coord;
            s1_y_reg    <= y_coord;
            s1_last_reg <= is_last;
        end
    end

    // pose is taken at acceptance, ahead of the item in the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg <= '0;
            pose_y_reg <= '0;
        end
        else if (pose_load)
        begin
            pose_x_reg <= x_coord;
            pose_y_reg <= y_coord;
        end
    end

    osh_trig_rom #(
        .ENTRIES (SINE_TABLE_ENTRIES)
    ) u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (pose_load),
        .heading (heading),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    osh_scan_min u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_adv && (s1_kind_reg == osh_pkg::KIND_SCAN)),
        .is_last    (s1_last_reg),
        .pose_x     (pose_x_reg),
        .pose_y     (pose_y_reg),
        .pt_x       (s1_x_reg),
        .pt_y       (s1_y_reg),
        .closest_sq (closest_sq)
    );

    osh_steer_calc u_steer (
        .cfg        (cfg_reg),
        .pose_x     (pose_x_reg),
        .pose_y     (pose_y_reg),
        .sin_val    (sin_val),
        .cos_val    (cos_val),
        .closest_sq (closest_sq),
        .result     (calc)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_is_cmd)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_is_cmd)
            res_reg <= calc;
    end

    assign out_valid      = out_valid_reg;
    assign forward_speed  = res_reg.speed;
    assign steering       = res_reg.steering;
    assign turn_direction = res_reg.dir;

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && turn_direction == osh_pkg::DIR_STOP)
            |-> (forward_speed == 16'd0 && steering == 16'sd0))
        else $error("stop result with nonzero speed or steering");

    a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_is_cmd) |=> out_valid)
        else $error("command left the input stage without a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s1_is_cmd))
        else $error("input stalled while the result side is free");

endmodule
